/* hw/rtl/bdlp_pkg.sv */
// Package for the push-button debouncer with long-press detection.
// Holds register indexes, reset values, event codes and default widths.
// No dependencies.
`default_nettype none

package bdlp_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MS_W        = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS         = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_MS       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_RELEASE_ENABLE = 2'd2;

  localparam logic [MS_W-1:0] DEBOUNCE_MS_RST   = 16'd50;
  localparam logic [MS_W-1:0] LONG_PRESS_MS_RST = 16'd1000;

  // button levels (active low)
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  localparam int EVENT_W = 3;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE         = 3'd0,
    EV_PRESS        = 3'd1,
    EV_RELEASE      = 3'd2,
    EV_LONG_RELEASE = 3'd3,
    EV_LONG_HOLD    = 3'd4
  } event_t;

endpackage

`default_nettype wire

/* hw/rtl/button_debounce_long_press.sv */
// Top level of the push-button debouncer with long-press detection.
// Depends on bdlp_pkg for register indexes, reset values and event codes.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid / in_stall   | button_level
//  out     | output    | out_valid / out_stall | event_res, debounced_level
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One tick per cycle while in_stall is low: each accepted beat updates the debounce
// state and loads the output register in the same cycle.
// The single output register sets the rate; in_stall rises only while that
// register is full and out_stall holds it.
// Reset clears the state to released with zero counters and restores the
// register reset values. cfg_ready is always high.
`default_nettype none

module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   button_level,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [EVENT_W-1:0]          event_res,
  output logic                        debounced_level,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH > MS_W) ? COUNT_WIDTH : MS_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // configuration registers
  logic [MS_W-1:0] debounce_ms;
  logic [MS_W-1:0] long_press_ms;
  logic            long_release_enable;

  // debounce state
  logic                   raw_level;
  logic                   stable_level;
  logic [COUNT_WIDTH-1:0] ticks_since_change;
  logic [COUNT_WIDTH-1:0] ticks_since_press;
  logic                   long_hold_reported;

  logic                   raw_level_next;
  logic                   stable_level_next;
  logic [COUNT_WIDTH-1:0] ticks_since_change_next;
  logic [COUNT_WIDTH-1:0] ticks_since_press_next;
  logic                   long_hold_reported_next;
  event_t                 event_next;

  // output register
  event_t event_q;
  logic   debounced_q;

  logic in_fire;
  logic level_ok;
  logic is_long;
  logic [COUNT_WIDTH-1:0] tsc_inc;
  logic [COUNT_WIDTH-1:0] tsp_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_fire   = in_valid & ~in_stall;

  assign event_res       = event_q;
  assign debounced_level = debounced_q;

  always_comb begin
    tsc_inc = (ticks_since_change == CNT_MAX) ? ticks_since_change
                                              : ticks_since_change + 1'b1;
    tsp_inc = (ticks_since_press == CNT_MAX) ? ticks_since_press
                                             : ticks_since_press + 1'b1;

    raw_level_next          = button_level;
    ticks_since_change_next = (button_level != raw_level) ? '0 : tsc_inc;
    ticks_since_press_next  = tsp_inc;
    long_hold_reported_next = long_hold_reported;
    stable_level_next       = stable_level;
    event_next              = EV_NONE;

    level_ok = CMP_W'(ticks_since_change_next) > CMP_W'(debounce_ms);
    is_long  = CMP_W'(tsp_inc) > CMP_W'(long_press_ms);

    if (level_ok) begin
      stable_level_next = button_level;
      if (stable_level == LEVEL_RELEASED && button_level == LEVEL_PRESSED) begin
        event_next              = EV_PRESS;
        long_hold_reported_next = 1'b0;
        ticks_since_press_next  = '0;
      end else if (stable_level == LEVEL_PRESSED &&
                   button_level == LEVEL_RELEASED) begin
        event_next = (long_release_enable && is_long) ? EV_LONG_RELEASE : EV_RELEASE;
      end else if (stable_level == LEVEL_PRESSED && !long_hold_reported && is_long) begin
        // held press: report long hold once
        event_next              = EV_LONG_HOLD;
        long_hold_reported_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms         <= DEBOUNCE_MS_RST;
      long_press_ms       <= LONG_PRESS_MS_RST;
      long_release_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE_MS:         debounce_ms         <= cfg_data;
        REG_LONG_PRESS_MS:       long_press_ms       <= cfg_data;
        REG_LONG_RELEASE_ENABLE: long_release_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_level          <= LEVEL_RELEASED;
      stable_level       <= LEVEL_RELEASED;
      ticks_since_change <= '0;
      ticks_since_press  <= '0;
      long_hold_reported <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (in_fire) begin
        raw_level          <= raw_level_next;
        stable_level       <= stable_level_next;
        ticks_since_change <= ticks_since_change_next;
        ticks_since_press  <= ticks_since_press_next;
        long_hold_reported <= long_hold_reported_next;
        out_valid          <= 1'b1;
      end else if (!out_stall) begin
        // drop the beat once taken
        out_valid <= 1'b0;
      end
    end
  end

  // payload holds while stalled, since in_fire is low then
  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_q     <= event_next;
      debounced_q <= stable_level_next;
    end
  end

endmodule

`default_nettype wire
